[hw/rtl/tmp_pkg.sv]
package tmp_pkg;

  typedef enum logic [1:0] {
    AR_MUL,
    AR_DIV,
    AR_SQRT
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_P_CHK,
    ST_P_CMP,
    ST_P_DIVT,
    ST_P_SQRT,
    ST_P_DIVA,
    ST_P_DIVB,
    ST_P_DIVC,
    ST_P_COMMIT,
    ST_E_START,
    ST_E_AD,
    ST_E_HALF,
    ST_E_VEL,
    ST_S_CHK,
    ST_S_END,
    ST_FIN
  } state_t;

  localparam logic [1:0] FN_PLAN = 2'd0;
  localparam logic [1:0] FN_EVAL = 2'd1;
  localparam logic [1:0] FN_STOP = 2'd2;

  localparam logic [1:0] REG_MOVE_DISTANCE = 2'd0;
  localparam logic [1:0] REG_PEAK_VELOCITY = 2'd1;
  localparam logic [1:0] REG_MAX_ACCEL     = 2'd2;
  localparam logic [1:0] REG_STOP_DECEL    = 2'd3;

  localparam logic [30:0] TIME_MAX = 31'h7FFF_FFFF;

endpackage

[hw/rtl/trapezoid_motion_profile.sv]
// Plan runs two multiplies, then a divide and a square root (triangular) or three divides
// (trapezoidal); DW = max(62, 31+2*FRAC_BITS) is the width of the bit-serial divider.
// Eval does three shared multiplies per phase; stop adds a divide and a multiply when it decelerates.
// Throughput: one transfer at a time; the next is taken once the result is registered.
// Reset (synchronous, rst high) clears registers, phases and profile to zero.
module trapezoid_motion_profile #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [39:0]   s_tdata,   // func[1:0], time_now[32:2], zero pad
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [103:0]  m_tdata,   // position, velocity, done_res, ok, duration, pad
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [30:0]   cfg_data
);

  localparam int DW = (31 + 2 * FRAC_BITS > 62) ? 31 + 2 * FRAC_BITS : 62;
  localparam logic signed [67:0] S_MAX = 68'sh0_7FFF_FFFF;
  localparam logic signed [67:0] S_MIN = -68'sh0_8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    logic signed [31:0] r;
    if (x > S_MAX) r = 32'sh7FFF_FFFF;
    else if (x < S_MIN) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic [30:0] clamp_q(input logic [DW-1:0] q);
    return ((q >> 31) != '0) ? tmp_pkg::TIME_MAX : q[30:0];
  endfunction

  tmp_pkg::state_t     state, state_next;
  tmp_pkg::arith_req_t req;

  logic [30:0]        move_distance, peak_velocity, max_accel, stop_decel;
  logic [30:0]        phase_duration [3];
  logic signed [31:0] phase_accel [3];
  logic [1:0]         phase_count;
  logic signed [31:0] start_position, start_velocity, end_position;
  logic [30:0]        profile_time;

  logic [1:0]         func_r;
  logic [30:0]        time_r;
  logic signed [31:0] pos, vel, ad;
  logic [30:0]        rem;
  logic [1:0]         idx;
  logic signed [65:0] half;
  logic [61:0]        vv;
  logic [30:0]        tacc, tcr;
  logic               tri_r;
  logic               done_r, ok_r;
  logic               issued;

  logic signed [32:0] mul_a, mul_b;
  logic [DW-1:0]      div_n;
  logic [30:0]        div_d;
  logic [63:0]        sqrt_x;
  logic               ar_done;
  logic signed [65:0] prod;
  logic [DW-1:0]      quot;
  logic [31:0]        root;

  logic               lim_zero;
  logic               eval_done;
  logic [30:0]        dt;
  logic signed [65:0] prod_sh, prod_half;
  logic [31:0]        mag;
  logic               stop_idle;
  logic               last_phase;
  logic               load_out;
  logic [32:0]        trap_sum;
  logic [31:0]        tri_sum;
  tmp_pkg::state_t    eval_exit;

  assign s_tready   = (state == tmp_pkg::ST_IDLE);
  assign lim_zero   = (move_distance == '0) || (peak_velocity == '0) || (max_accel == '0);
  assign eval_done  = (time_r >= profile_time);
  assign dt         = (rem < phase_duration[idx]) ? rem : phase_duration[idx];
  assign prod_sh    = prod >>> FRAC_BITS;
  assign prod_half  = prod >>> (FRAC_BITS + 1);
  assign mag        = vel[31] ? (32'd0 - vel) : vel;
  assign stop_idle  = (stop_decel == '0) || (vel == '0);
  assign last_phase = (rem == dt) || (idx == phase_count - 2'd1) || (idx == 2'd2);
  assign load_out   = (state == tmp_pkg::ST_FIN) && (!m_tvalid || m_tready);
  assign trap_sum   = {2'b00, tacc} + {2'b00, tacc} + {2'b00, tcr};
  assign tri_sum    = {tacc, 1'b0};
  assign eval_exit  = (func_r == tmp_pkg::FN_STOP) ? tmp_pkg::ST_S_CHK : tmp_pkg::ST_FIN;
  assign sqrt_x     = 64'(quot);

  tmp_arith #(
    .DIV_W (DW)
  ) u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .div_n  (div_n),
    .div_d  (div_d),
    .sqrt_x (sqrt_x),
    .done   (ar_done),
    .prod   (prod),
    .quot   (quot),
    .root   (root)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= tmp_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    req.start  = 1'b0;
    req.op     = tmp_pkg::AR_MUL;
    mul_a      = '0;
    mul_b      = '0;
    div_n      = '0;
    div_d      = max_accel;
    unique case (state)
      tmp_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tdata[1:0] == tmp_pkg::FN_PLAN) ? tmp_pkg::ST_P_CHK
                                                          : tmp_pkg::ST_E_START;
        end
      end
      tmp_pkg::ST_P_CHK: begin
        mul_a = {2'b00, peak_velocity};
        mul_b = {2'b00, peak_velocity};
        req.start = !issued && !lim_zero;
        if (lim_zero) state_next = tmp_pkg::ST_FIN;
        else if (ar_done) state_next = tmp_pkg::ST_P_CMP;
      end
      tmp_pkg::ST_P_CMP: begin
        mul_a = {2'b00, move_distance};
        mul_b = {2'b00, max_accel};
        req.start = !issued;
        if (ar_done) begin
          state_next = (vv >= prod[61:0]) ? tmp_pkg::ST_P_DIVT : tmp_pkg::ST_P_DIVA;
        end
      end
      tmp_pkg::ST_P_DIVT: begin
        div_n = DW'({move_distance, {(2 * FRAC_BITS){1'b0}}});
        req.op = tmp_pkg::AR_DIV;
        req.start = !issued;
        if (ar_done) begin
          state_next = ((quot >> 64) != '0) ? tmp_pkg::ST_P_COMMIT : tmp_pkg::ST_P_SQRT;
        end
      end
      tmp_pkg::ST_P_SQRT: begin
        req.op = tmp_pkg::AR_SQRT;
        req.start = !issued;
        if (ar_done) state_next = tmp_pkg::ST_P_COMMIT;
      end
      tmp_pkg::ST_P_DIVA: begin
        div_n = DW'({peak_velocity, {FRAC_BITS{1'b0}}});
        req.op = tmp_pkg::AR_DIV;
        req.start = !issued;
        if (ar_done) state_next = tmp_pkg::ST_P_DIVB;
      end
      tmp_pkg::ST_P_DIVB: begin
        div_n = DW'(vv);
        req.op = tmp_pkg::AR_DIV;
        req.start = !issued;
        if (ar_done) state_next = tmp_pkg::ST_P_DIVC;
      end
      tmp_pkg::ST_P_DIVC: begin
        div_n = DW'({tcr, {FRAC_BITS{1'b0}}});
        div_d = peak_velocity;
        req.op = tmp_pkg::AR_DIV;
        req.start = !issued;
        if (ar_done) state_next = tmp_pkg::ST_P_COMMIT;
      end
      tmp_pkg::ST_P_COMMIT: state_next = tmp_pkg::ST_FIN;
      tmp_pkg::ST_E_START: begin
        if (eval_done || time_r == '0 || phase_count == '0) state_next = eval_exit;
        else state_next = tmp_pkg::ST_E_AD;
      end
      tmp_pkg::ST_E_AD: begin
        mul_a = {phase_accel[idx][31], phase_accel[idx]};
        mul_b = {2'b00, dt};
        req.start = !issued;
        if (ar_done) state_next = tmp_pkg::ST_E_HALF;
      end
      tmp_pkg::ST_E_HALF: begin
        mul_a = {ad[31], ad};
        mul_b = {2'b00, dt};
        req.start = !issued;
        if (ar_done) state_next = tmp_pkg::ST_E_VEL;
      end
      tmp_pkg::ST_E_VEL: begin
        mul_a = {vel[31], vel};
        mul_b = {2'b00, dt};
        req.start = !issued;
        if (ar_done) state_next = last_phase ? eval_exit : tmp_pkg::ST_E_AD;
      end
      tmp_pkg::ST_S_CHK: begin
        div_n = DW'({mag, {FRAC_BITS{1'b0}}});
        div_d = stop_decel;
        req.op = tmp_pkg::AR_DIV;
        req.start = !issued && !stop_idle;
        if (stop_idle) state_next = tmp_pkg::ST_FIN;
        else if (ar_done) state_next = tmp_pkg::ST_S_END;
      end
      tmp_pkg::ST_S_END: begin
        mul_a = {vel[31], vel};
        mul_b = {2'b00, tacc};
        req.start = !issued;
        if (ar_done) state_next = tmp_pkg::ST_FIN;
      end
      tmp_pkg::ST_FIN: begin
        if (!m_tvalid || m_tready) state_next = tmp_pkg::ST_IDLE;
      end
      default: state_next = tmp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      move_distance  <= '0;
      peak_velocity  <= '0;
      max_accel      <= '0;
      stop_decel     <= '0;
      for (int i = 0; i < 3; i++) begin
        phase_duration[i] <= '0;
        phase_accel[i]    <= '0;
      end
      phase_count    <= '0;
      start_position <= '0;
      start_velocity <= '0;
      end_position   <= '0;
      profile_time   <= '0;
      issued         <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tmp_pkg::REG_MOVE_DISTANCE: move_distance <= cfg_data;
          tmp_pkg::REG_PEAK_VELOCITY: peak_velocity <= cfg_data;
          tmp_pkg::REG_MAX_ACCEL:     max_accel     <= cfg_data;
          tmp_pkg::REG_STOP_DECEL:    stop_decel    <= cfg_data;
          default: ;
        endcase
      end
      if (ar_done) issued <= 1'b0;
      else if (req.start) issued <= 1'b1;
      if (load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      if (state == tmp_pkg::ST_P_COMMIT) begin
        start_position    <= '0;
        start_velocity    <= '0;
        end_position      <= {1'b0, move_distance};
        phase_accel[0]    <= {1'b0, max_accel};
        phase_duration[0] <= tacc;
        if (tri_r) begin
          phase_count       <= 2'd2;
          phase_duration[1] <= tacc;
          phase_accel[1]    <= 32'd0 - {1'b0, max_accel};
          profile_time      <= tri_sum[31] ? tmp_pkg::TIME_MAX : tri_sum[30:0];
        end else begin
          phase_count       <= 2'd3;
          phase_duration[1] <= tcr;
          phase_duration[2] <= tacc;
          phase_accel[1]    <= '0;
          phase_accel[2]    <= 32'd0 - {1'b0, max_accel};
          profile_time      <= (trap_sum[32:31] != '0) ? tmp_pkg::TIME_MAX : trap_sum[30:0];
        end
      end
      if (state == tmp_pkg::ST_S_CHK) begin
        start_position <= pos;
        start_velocity <= vel;
        if (stop_idle) begin
          phase_count  <= '0;
          profile_time <= '0;
          end_position <= pos;
        end
      end
      if (state == tmp_pkg::ST_S_END && ar_done) begin
        phase_count       <= 2'd1;
        phase_duration[0] <= tacc;
        phase_accel[0]    <= vel[31] ? {1'b0, stop_decel} : (32'd0 - {1'b0, stop_decel});
        profile_time      <= tacc;
        end_position      <= sat32(68'(pos) + 68'(prod_half));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == tmp_pkg::ST_IDLE && s_tvalid) begin
      func_r <= s_tdata[1:0];
      time_r <= s_tdata[32:2];
    end
    unique case (state)
      tmp_pkg::ST_P_CHK: begin
        pos    <= '0;
        vel    <= '0;
        done_r <= 1'b0;
        ok_r   <= !lim_zero;
        if (ar_done) vv <= prod[61:0];
      end
      tmp_pkg::ST_P_CMP: if (ar_done) tri_r <= (vv >= prod[61:0]);
      tmp_pkg::ST_P_DIVT: if (ar_done) tacc <= tmp_pkg::TIME_MAX;
      tmp_pkg::ST_P_SQRT: if (ar_done) tacc <= root[31] ? tmp_pkg::TIME_MAX : root[30:0];
      tmp_pkg::ST_P_DIVA: if (ar_done) tacc <= clamp_q(quot);
      tmp_pkg::ST_P_DIVB: if (ar_done) tcr <= move_distance - quot[30:0];
      tmp_pkg::ST_P_DIVC: if (ar_done) tcr <= clamp_q(quot);
      tmp_pkg::ST_E_START: begin
        ok_r   <= 1'b1;
        done_r <= eval_done;
        rem    <= time_r;
        idx    <= '0;
        if (eval_done) begin
          pos <= end_position;
          vel <= '0;
        end else begin
          pos <= start_position;
          vel <= start_velocity;
        end
      end
      tmp_pkg::ST_E_AD: if (ar_done) ad <= sat32(68'(prod_sh));
      tmp_pkg::ST_E_HALF: if (ar_done) half <= prod_half;
      tmp_pkg::ST_E_VEL: begin
        if (ar_done) begin
          pos <= sat32(68'(pos) + 68'(prod_sh) + 68'(half));
          vel <= sat32(68'(vel) + 68'(ad));
          rem <= rem - dt;
          idx <= idx + 2'd1;
        end
      end
      tmp_pkg::ST_S_CHK: if (ar_done) tacc <= clamp_q(quot);
      default: ;
    endcase
    if (load_out) begin
      m_tdata <= {7'd0, profile_time, ok_r, done_r, vel, pos};
    end
  end

endmodule

[hw/rtl/tmp_arith.sv]
module tmp_arith #(
  parameter int DIV_W = 63
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tmp_pkg::arith_req_t      req,
  input  logic signed [32:0]       mul_a,
  input  logic signed [32:0]       mul_b,
  input  logic [DIV_W-1:0]         div_n,
  input  logic [30:0]              div_d,
  input  logic [63:0]              sqrt_x,
  output logic                     done,
  output logic signed [65:0]       prod,
  output logic [DIV_W-1:0]         quot,
  output logic [31:0]              root
);

  localparam int CW = $clog2(DIV_W + 1);

  logic                busy;
  logic [CW-1:0]       cnt;
  tmp_pkg::arith_op_t  op_r;
  logic [30:0]         dr;
  logic [30:0]         dd;
  logic [32:0]         diff;
  logic [63:0]         sx;
  logic [34:0]         sr;
  logic [34:0]         scur;
  logic [34:0]         strial;
  logic                take;

  assign take   = req.start && !busy;
  assign diff   = {1'b0, dr, quot[DIV_W-1]} - {2'b00, dd};
  assign scur   = {sr[32:0], sx[63:62]};
  assign strial = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (take) begin
        unique case (req.op)
          tmp_pkg::AR_MUL: done <= 1'b1;
          tmp_pkg::AR_DIV: begin
            busy <= 1'b1;
            cnt  <= CW'(DIV_W);
          end
          tmp_pkg::AR_SQRT: begin
            busy <= 1'b1;
            cnt  <= CW'(32);
          end
          default: done <= 1'b1;
        endcase
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_r <= req.op;
      unique case (req.op)
        tmp_pkg::AR_MUL: prod <= mul_a * mul_b;
        tmp_pkg::AR_DIV: begin
          quot <= div_n;
          dr   <= '0;
          dd   <= div_d;
        end
        tmp_pkg::AR_SQRT: begin
          sx   <= sqrt_x;
          sr   <= '0;
          root <= '0;
        end
        default: prod <= '0;
      endcase
    end else if (busy) begin
      if (op_r == tmp_pkg::AR_DIV) begin
        if (!diff[32]) begin
          dr   <= diff[30:0];
          quot <= {quot[DIV_W-2:0], 1'b1};
        end else begin
          dr   <= {dr[29:0], quot[DIV_W-1]};
          quot <= {quot[DIV_W-2:0], 1'b0};
        end
      end else begin
        sx <= {sx[61:0], 2'b00};
        if (scur >= strial) begin
          sr   <= scur - strial;
          root <= {root[30:0], 1'b1};
        end else begin
          sr   <= scur;
          root <= {root[30:0], 1'b0};
        end
      end
    end
  end

endmodule
